### rtl/core/mbrq_pkg.sv
// Shared types and constants of the multi-channel byte ring queue.
`default_nettype none

package mbrq_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int BUF_DEPTH_DEF = 64;

    localparam int NUM_CFG   = 4;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W    = 8;
    localparam int LEN_W     = 7;
    localparam int CH_FLD_W  = 2;
    localparam int CNT_W     = 7;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_NOT_SETUP = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } state_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [CH_FLD_W-1:0]  channel;
        logic [DATA_W-1:0]    data_in;
        logic [LEN_W-1:0]     run_length;
        logic                 run_first;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    data_out;
        logic                 last;
        logic [CNT_W-1:0]     popped_count;
        logic [CNT_W-1:0]     fill_count;
        logic                 is_empty;
        logic                 is_full;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/core/mbrq_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
`default_nettype none

interface mbrq_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/core/mbrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mbrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/multi_channel_byte_ring_queue.sv
// Top level: per-channel byte FIFOs sharing one ring RAM.
// Push, clear and query items, and pops that move no byte, give one registered result;
// such items can be accepted every cycle while the result slot drains.
// A pop of n bytes closes the input until its last byte reaches the result slot; bytes
// leave one per cycle while the slot drains, via the single RAM read port's register.
// Reset (async, active low) zeroes all capacities and empties every channel;
// the ring RAM is not cleared and needs no clearing pass.
`default_nettype none

module multi_channel_byte_ring_queue #(
    parameter int CHANNELS  = mbrq_pkg::CHANNELS_DEF,
    parameter int BUF_DEPTH = mbrq_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    mbrq_stream_if.sink                           cmd,
    mbrq_stream_if.source                         result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mbrq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mbrq_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int RAM_DEPTH = CHANNELS * BUF_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int LEN_W     = mbrq_pkg::LEN_W;
    localparam int CNT_W     = mbrq_pkg::CNT_W;

    // ---------------------------------------------------------------- helpers
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                  input logic [FILL_W-1:0] capv);
        logic [FILL_W:0] n;
        n = (FILL_W+1)'(idx) + 1'b1;
        return (n >= (FILL_W+1)'(capv)) ? '0 : IDX_W'(n);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CH_W-1:0] c,
                                                   input logic [IDX_W-1:0] i);
        return ADDR_W'(c) * ADDR_W'(BUF_DEPTH) + ADDR_W'(i);
    endfunction

    // ---------------------------------------------------------------- state
    mbrq_pkg::state_t state_reg, state_next;

    logic [mbrq_pkg::CFG_W-1:0] capacity_reg [mbrq_pkg::NUM_CFG];
    logic [mbrq_pkg::CFG_W-1:0] capacity_next [mbrq_pkg::NUM_CFG];
    logic [IDX_W-1:0]  rd_idx_reg  [CHANNELS];
    logic [IDX_W-1:0]  rd_idx_next [CHANNELS];
    logic [IDX_W-1:0]  wr_idx_reg  [CHANNELS];
    logic [IDX_W-1:0]  wr_idx_next [CHANNELS];
    logic [FILL_W-1:0] fill_reg    [CHANNELS];
    logic [FILL_W-1:0] fill_next   [CHANNELS];
    logic              run_acc_reg  [CHANNELS];
    logic              run_acc_next [CHANNELS];

    logic [CH_W-1:0]   pop_ch_reg,   pop_ch_next;
    logic [IDX_W-1:0]  pop_ptr_reg,  pop_ptr_next;
    logic [FILL_W-1:0] pop_cap_reg,  pop_cap_next;
    logic [FILL_W-1:0] pop_left_reg, pop_left_next;
    logic [FILL_W-1:0] pop_cnt_reg,  pop_cnt_next;
    logic [FILL_W-1:0] pop_fill_reg, pop_fill_next;
    logic              pend_reg,      pend_next;
    logic              pend_last_reg, pend_last_next;

    logic                out_valid_reg, out_valid_next;
    mbrq_pkg::out_item_t out_item_reg,  out_item_next;

    // ---------------------------------------------------------------- decode
    logic                       in_acc;
    logic                       ch_ok;
    logic [CH_W-1:0]            ci;
    logic [mbrq_pkg::CFG_W-1:0] cap_raw;
    logic [FILL_W-1:0]          cap;
    logic [FILL_W-1:0]          cur_fill;
    logic [IDX_W-1:0]           cur_rd;
    logic [IDX_W-1:0]           cur_wr;
    logic                       cur_acc;
    logic [LEN_W:0]             room_sum;
    logic [FILL_W:0]            rd_sum;
    logic [IDX_W-1:0]           rd_end;

    mbrq_pkg::status_t   dec_status;
    logic [FILL_W-1:0]   dec_fill;
    logic [FILL_W-1:0]   dec_cnt;
    logic                dec_store;
    logic                dec_acc_wr;
    logic                dec_acc_val;
    logic                dec_clear;
    logic                dec_pop_go;
    mbrq_pkg::out_item_t dec_res;

    logic                move;
    logic                issue;
    logic [mbrq_pkg::DATA_W-1:0] ram_rd_data;

    assign in_acc  = cmd.valid && cmd.ready;
    assign ch_ok   = (32'(cmd.payload.channel) < CHANNELS);
    assign ci      = ch_ok ? CH_W'(cmd.payload.channel) : '0;
    assign cap_raw = capacity_reg[cmd.payload.channel];
    assign cap     = !ch_ok ? '0 :
                     (cap_raw > mbrq_pkg::CFG_W'(BUF_DEPTH)) ? FILL_W'(BUF_DEPTH) :
                     FILL_W'(cap_raw);
    assign cur_fill = fill_reg[ci];
    assign cur_rd   = rd_idx_reg[ci];
    assign cur_wr   = wr_idx_reg[ci];
    assign cur_acc  = run_acc_reg[ci];
    assign room_sum = (LEN_W+1)'(cmd.payload.run_length) + (LEN_W+1)'(cur_fill);

    always_comb
    begin
        dec_status  = mbrq_pkg::ST_OK;
        dec_fill    = cur_fill;
        dec_cnt     = cur_fill;
        dec_store   = 1'b0;
        dec_acc_wr  = 1'b0;
        dec_acc_val = 1'b0;
        dec_clear   = 1'b0;
        dec_pop_go  = 1'b0;
        case (cmd.payload.opcode)
            mbrq_pkg::OP_CLEAR:
            begin
                dec_fill = '0;
                if (ch_ok)
                begin
                    dec_clear = 1'b1;
                end
                else
                begin
                    dec_status = mbrq_pkg::ST_NOT_SETUP;
                end
            end
            mbrq_pkg::OP_PUSH:
            begin
                if (cap == '0)
                begin
                    dec_status = mbrq_pkg::ST_NOT_SETUP;
                    dec_fill   = '0;
                end
                else if (cmd.payload.run_first)
                begin
                    // check room for the whole run on its first byte
                    dec_acc_wr = 1'b1;
                    if (cmd.payload.run_length != '0 && room_sum <= (LEN_W+1)'(cap))
                    begin
                        dec_acc_val = 1'b1;
                        dec_store   = 1'b1;
                    end
                    else
                    begin
                        dec_status = mbrq_pkg::ST_REFUSED;
                    end
                end
                else if (cur_acc)
                begin
                    if (cur_fill < cap)
                    begin
                        dec_store = 1'b1;
                    end
                    else
                    begin
                        dec_acc_wr = 1'b1;
                        dec_status = mbrq_pkg::ST_REFUSED;
                    end
                end
                else
                begin
                    dec_status = mbrq_pkg::ST_REFUSED;
                end
                if (dec_store)
                begin
                    dec_fill = cur_fill + 1'b1;
                end
            end
            mbrq_pkg::OP_POP:
            begin
                if (cap == '0)
                begin
                    dec_status = mbrq_pkg::ST_NOT_SETUP;
                    dec_fill   = '0;
                end
                else if (cmd.payload.run_length == '0)
                begin
                    dec_cnt    = cur_fill;
                    dec_pop_go = (cur_fill != '0);
                end
                else if (cmd.payload.run_length <= LEN_W'(cur_fill))
                begin
                    dec_cnt    = FILL_W'(cmd.payload.run_length);
                    dec_pop_go = 1'b1;
                end
                else
                begin
                    dec_status = mbrq_pkg::ST_REFUSED;
                end
                if (dec_pop_go)
                begin
                    dec_fill = cur_fill - dec_cnt;
                end
            end
            mbrq_pkg::OP_QUERY:
            begin
                if (cap == '0)
                begin
                    dec_status = mbrq_pkg::ST_NOT_SETUP;
                    dec_fill   = '0;
                end
            end
            default:
            begin
                dec_status = mbrq_pkg::ST_OK;
            end
        endcase
    end

    // read index after the whole pop, wrapped at the capacity
    assign rd_sum = (FILL_W+1)'(cur_rd) + (FILL_W+1)'(dec_cnt);
    assign rd_end = (rd_sum >= (FILL_W+1)'(cap)) ? IDX_W'(rd_sum - (FILL_W+1)'(cap))
                                                 : IDX_W'(rd_sum);

    always_comb
    begin
        dec_res.status       = dec_status;
        dec_res.data_out     = '0;
        dec_res.last         = 1'b1;
        dec_res.popped_count = '0;
        dec_res.fill_count   = CNT_W'(dec_fill);
        dec_res.is_empty     = (dec_fill == '0);
        dec_res.is_full      = (cap != '0) && (dec_fill == cap);
    end

    // ---------------------------------------------------------------- channel table
    always_comb
    begin
        capacity_next = capacity_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        fill_next     = fill_reg;
        run_acc_next  = run_acc_reg;
        if (cfg_wr_en)
        begin
            capacity_next[cfg_index] = cfg_wdata;
            if (32'(cfg_index) < CHANNELS)
            begin
                rd_idx_next[CH_W'(cfg_index)]  = '0;
                wr_idx_next[CH_W'(cfg_index)]  = '0;
                fill_next[CH_W'(cfg_index)]    = '0;
                run_acc_next[CH_W'(cfg_index)] = 1'b0;
            end
        end
        if (in_acc)
        begin
            if (dec_clear)
            begin
                rd_idx_next[ci]  = '0;
                wr_idx_next[ci]  = '0;
                fill_next[ci]    = '0;
                run_acc_next[ci] = 1'b0;
            end
            if (dec_acc_wr)
            begin
                run_acc_next[ci] = dec_acc_val;
            end
            if (dec_store)
            begin
                wr_idx_next[ci] = wrap_inc(cur_wr, cap);
                fill_next[ci]   = dec_fill;
            end
            if (dec_pop_go)
            begin
                rd_idx_next[ci] = rd_end;
                fill_next[ci]   = dec_fill;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mbrq_pkg::NUM_CFG; i++)
            begin
                capacity_reg[i] <= '0;
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                rd_idx_reg[i]  <= '0;
                wr_idx_reg[i]  <= '0;
                fill_reg[i]    <= '0;
                run_acc_reg[i] <= 1'b0;
            end
        end
        else
        begin
            capacity_reg <= capacity_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            fill_reg     <= fill_next;
            run_acc_reg  <= run_acc_next;
        end
    end

    // ---------------------------------------------------------------- ring RAM
    mbrq_ram #(
        .WIDTH (mbrq_pkg::DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_acc && dec_store),
        .wr_addr (slot_addr(ci, cur_wr)),
        .wr_data (cmd.payload.data_in),
        .rd_en   (issue),
        .rd_addr (slot_addr(pop_ch_reg, pop_ptr_reg)),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbrq_pkg::S_IDLE:
            begin
                if (in_acc && dec_pop_go)
                begin
                    state_next = mbrq_pkg::S_POP;
                end
            end
            mbrq_pkg::S_POP:
            begin
                if (pop_left_reg == '0 && move)
                begin
                    state_next = mbrq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbrq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready = 1'b0;
        issue     = 1'b0;
        // a pending RAM byte moves once the result slot is free
        move      = pend_reg && (!out_valid_reg || result.ready);
        case (state_reg)
            mbrq_pkg::S_IDLE:
            begin
                cmd.ready = !out_valid_reg || result.ready;
            end
            mbrq_pkg::S_POP:
            begin
                issue = (pop_left_reg != '0) && (!pend_reg || move);
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pop_ch_next    = pop_ch_reg;
        pop_ptr_next   = pop_ptr_reg;
        pop_cap_next   = pop_cap_reg;
        pop_left_next  = pop_left_reg;
        pop_cnt_next   = pop_cnt_reg;
        pop_fill_next  = pop_fill_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        if (in_acc && dec_pop_go)
        begin
            pop_ch_next   = ci;
            pop_ptr_next  = cur_rd;
            pop_cap_next  = cap;
            pop_left_next = dec_cnt;
            pop_cnt_next  = dec_cnt;
            pop_fill_next = dec_fill;
        end
        else if (issue)
        begin
            pop_ptr_next  = wrap_inc(pop_ptr_reg, pop_cap_reg);
            pop_left_next = pop_left_reg - 1'b1;
        end
        if (issue)
        begin
            pend_next      = 1'b1;
            pend_last_next = (pop_left_reg == FILL_W'(1));
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_acc && !dec_pop_go)
        begin
            out_valid_next = 1'b1;
            out_item_next  = dec_res;
        end
        else if (move)
        begin
            out_valid_next             = 1'b1;
            out_item_next.status       = mbrq_pkg::ST_OK;
            out_item_next.data_out     = ram_rd_data;
            out_item_next.last         = pend_last_reg;
            out_item_next.popped_count = pend_last_reg ? CNT_W'(pop_cnt_reg) : '0;
            out_item_next.fill_count   = CNT_W'(pop_fill_reg);
            out_item_next.is_empty     = (pop_fill_reg == '0);
            out_item_next.is_full      = (pop_cap_reg != '0) && (pop_fill_reg == pop_cap_reg);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbrq_pkg::S_IDLE;
            pop_left_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pop_left_reg  <= pop_left_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_ch_reg   <= pop_ch_next;
        pop_ptr_reg  <= pop_ptr_next;
        pop_cap_reg  <= pop_cap_next;
        pop_cnt_reg  <= pop_cnt_next;
        pop_fill_reg <= pop_fill_next;
        out_item_reg <= out_item_next;
    end

    // ---------------------------------------------------------------- checks
    a_pend_only_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == mbrq_pkg::S_POP)
        else $error("RAM byte pending outside a pop");

    a_pop_starts_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbrq_pkg::S_POP && $past(state_reg) == mbrq_pkg::S_IDLE)
        |-> pop_left_reg != '0)
        else $error("pop entered with nothing to read");

    a_drain_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbrq_pkg::S_POP && pop_left_reg == '0) |-> pend_reg)
        else $error("pop stalled with no byte in flight");

    a_last_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (move && pend_last_reg) |-> pop_left_reg == '0)
        else $error("last byte delivered while reads remain");

endmodule

`default_nettype wire

### sim/multi_channel_byte_ring_queue_test.sv
// Testbench for multi_channel_byte_ring_queue: directed table, random item runs, field checks.
`timescale 1ns / 1ps

module multi_channel_byte_ring_queue_test;

    localparam int RING_DEPTH   = mbrq_pkg::BUF_DEPTH_DEF;
    localparam int NCH          = mbrq_pkg::CHANNELS_DEF;
    localparam int NCFG         = mbrq_pkg::NUM_CFG;
    localparam int IDXW         = mbrq_pkg::CFG_IDX_W;
    localparam int CFGW         = mbrq_pkg::CFG_W;
    localparam int CNTW         = mbrq_pkg::CNT_W;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 3;

    typedef struct packed {
        bit                   is_cfg;
        bit                   typed;
        logic [IDXW-1:0]      reg_idx;
        logic [CFGW-1:0]      reg_val;
        mbrq_pkg::in_item_t   item;
        mbrq_pkg::out_item_t  res;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic            cfg_wr_en;
    logic [IDXW-1:0] cfg_index;
    logic [CFGW-1:0] cfg_wdata;

    mbrq_stream_if #(.item_t(mbrq_pkg::in_item_t))  cmd_if ();
    mbrq_stream_if #(.item_t(mbrq_pkg::out_item_t)) result_if ();

    multi_channel_byte_ring_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Shadow state of the queue channels
    logic [CFGW-1:0] cap_reg  [NCFG];
    logic [7:0]      ring_mem [NCH*RING_DEPTH];
    logic [5:0]      rd_idx   [NCH];
    logic [5:0]      wr_idx   [NCH];
    logic [CNTW-1:0] fill_lvl [NCH];
    logic            run_ok   [NCH];

    mbrq_pkg::out_item_t pending_results[$];
    plan_row_t dir_plan[$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    function automatic int eff_capacity(input int ch);
        return (cap_reg[ch] > RING_DEPTH) ? RING_DEPTH : int'(cap_reg[ch]);
    endfunction

    function automatic void clear_channel(input int ch);
        rd_idx[ch]   = '0;
        wr_idx[ch]   = '0;
        fill_lvl[ch] = '0;
        run_ok[ch]   = 1'b0;
    endfunction

    function automatic logic [5:0] step_index(input logic [5:0] idx, input int cap);
        int n;
        n = int'(idx) + 1;
        return (n >= cap) ? 6'd0 : 6'(n);
    endfunction

    function automatic mbrq_pkg::out_item_t make_result(input mbrq_pkg::status_t st,
                                                        input logic [7:0] data,
                                                        input bit last, input int popped,
                                                        input int fill, input int cap);
        mbrq_pkg::out_item_t r;
        r.status       = st;
        r.data_out     = data;
        r.last         = last;
        r.popped_count = CNTW'(popped);
        r.fill_count   = CNTW'(fill);
        r.is_empty     = (fill == 0);
        r.is_full      = (cap != 0 && fill == cap);
        return r;
    endfunction

    // Work out the results of one accepted item and advance the shadow state
    function automatic void predict_ring_results(input mbrq_pkg::in_item_t it);
        int ch, cap, fill, cnt, i;
        logic [7:0] popped[$];
        mbrq_pkg::status_t st;
        bit keep;
        ch  = it.channel;
        cap = eff_capacity(ch);
        if (it.opcode == mbrq_pkg::OP_CLEAR) begin
            clear_channel(ch);
            pending_results.push_back(make_result(mbrq_pkg::ST_OK, 8'h00, 1'b1, 0, 0, cap));
            return;
        end
        if (cap == 0) begin
            pending_results.push_back(make_result(mbrq_pkg::ST_NOT_SETUP, 8'h00, 1'b1,
                                                  0, 0, 0));
            return;
        end
        fill = fill_lvl[ch];
        case (it.opcode)
            mbrq_pkg::OP_PUSH:
            begin
                st   = mbrq_pkg::ST_OK;
                keep = 1'b0;
                if (it.run_first) begin
                    if (it.run_length != 0 && fill + int'(it.run_length) <= cap) begin
                        run_ok[ch] = 1'b1;
                        keep = 1'b1;
                    end
                    else begin
                        run_ok[ch] = 1'b0;
                        st = mbrq_pkg::ST_REFUSED;
                    end
                end
                else if (run_ok[ch]) begin
                    if (fill < cap)
                        keep = 1'b1;
                    else begin
                        run_ok[ch] = 1'b0;
                        st = mbrq_pkg::ST_REFUSED;
                    end
                end
                else
                    st = mbrq_pkg::ST_REFUSED;
                if (keep) begin
                    ring_mem[ch*RING_DEPTH + int'(wr_idx[ch])] = it.data_in;
                    wr_idx[ch] = step_index(wr_idx[ch], cap);
                    fill++;
                    fill_lvl[ch] = CNTW'(fill);
                end
                pending_results.push_back(make_result(st, 8'h00, 1'b1, 0, fill, cap));
            end
            mbrq_pkg::OP_QUERY:
                pending_results.push_back(make_result(mbrq_pkg::ST_OK, 8'h00, 1'b1, 0,
                                                      fill, cap));
            default:
            begin
                if (it.run_length == 0)
                    cnt = fill;
                else if (int'(it.run_length) <= fill)
                    cnt = it.run_length;
                else begin
                    pending_results.push_back(make_result(mbrq_pkg::ST_REFUSED, 8'h00, 1'b1,
                                                          0, fill, cap));
                    return;
                end
                if (cnt == 0) begin
                    pending_results.push_back(make_result(mbrq_pkg::ST_OK, 8'h00, 1'b1, 0,
                                                          fill, cap));
                    return;
                end
                for (i = 0; i < cnt; i++) begin
                    popped.push_back(ring_mem[ch*RING_DEPTH + int'(rd_idx[ch])]);
                    rd_idx[ch] = step_index(rd_idx[ch], cap);
                end
                fill -= cnt;
                fill_lvl[ch] = CNTW'(fill);
                for (i = 0; i < cnt; i++)
                    pending_results.push_back(make_result(mbrq_pkg::ST_OK, popped[i],
                                                          i == cnt - 1,
                                                          (i == cnt - 1) ? cnt : 0,
                                                          fill, cap));
            end
        endcase
    endfunction

    function automatic string show_result(input mbrq_pkg::out_item_t r);
        return $sformatf("status=%0d data=%02h last=%0b popped=%0d fill=%0d empty=%0b full=%0b",
                         r.status, r.data_out, r.last, r.popped_count, r.fill_count,
                         r.is_empty, r.is_full);
    endfunction

    function automatic void report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endfunction

    function automatic void plan_cfg(input int idx, input int val);
        plan_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = IDXW'(idx);
        row.reg_val = CFGW'(val);
        dir_plan.push_back(row);
    endfunction

    // A typed row carries a single-result expectation read straight off the spec
    function automatic void plan_item(input mbrq_pkg::opcode_t op, input int ch,
                                      input int data, input int len, input bit first,
                                      input bit typed, input mbrq_pkg::status_t st,
                                      input int fill, input bit full);
        plan_row_t row;
        row                  = '0;
        row.typed            = typed;
        row.item.opcode      = op;
        row.item.channel     = mbrq_pkg::CH_FLD_W'(ch);
        row.item.data_in     = mbrq_pkg::DATA_W'(data);
        row.item.run_length  = mbrq_pkg::LEN_W'(len);
        row.item.run_first   = first;
        row.res.status       = st;
        row.res.last         = 1'b1;
        row.res.fill_count   = CNTW'(fill);
        row.res.is_empty     = (fill == 0);
        row.res.is_full      = full;
        dir_plan.push_back(row);
    endfunction

    task automatic send_cmd(input mbrq_pkg::in_item_t it, input bit typed,
                            input mbrq_pkg::out_item_t typed_res);
        int n0;
        cmd_if.payload <= it;
        cmd_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        n0 = pending_results.size();
        predict_ring_results(it);
        if (typed) begin
            while (pending_results.size() > n0)
                void'(pending_results.pop_back());
            pending_results.push_back(typed_res);
        end
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Lower valid and hold until every expected result is out
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input int idx, input int val);
        wait_drained();
        cfg_index <= IDXW'(idx);
        cfg_wdata <= CFGW'(val);
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cap_reg[idx] = CFGW'(val);
        clear_channel(idx);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_capacity();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return RING_DEPTH;
            3: return 127;
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    // Mostly well-formed push runs, pops, queries and clears on set-up channels, with some noise
    task automatic run_random(input int n_items, input int pause_at);
        int sent, ch, cap, f, run_len, extra, k, pick;
        mbrq_pkg::in_item_t it;
        sent = 0;
        while (sent < n_items) begin
            if (pause_at >= 0 && sent >= pause_at) begin
                wait_drained();
                pause_at = -1;
            end
            ch   = $urandom_range(0, 3);
            cap  = eff_capacity(ch);
            f    = fill_lvl[ch];
            pick = $urandom_range(0, 99);
            it.channel    = mbrq_pkg::CH_FLD_W'(ch);
            it.data_in    = mbrq_pkg::DATA_W'($urandom_range(0, 255));
            it.run_first  = 1'b0;
            it.run_length = '0;
            if (cap == 0 || pick < 12) begin
                it.opcode     = mbrq_pkg::opcode_t'($urandom_range(0, 3));
                it.channel    = mbrq_pkg::CH_FLD_W'($urandom_range(0, 3));
                it.run_length = mbrq_pkg::LEN_W'($urandom_range(0, 127));
                it.run_first  = 1'($urandom_range(0, 1));
                send_cmd(it, 1'b0, '0);
                sent++;
            end
            else if (pick < 55) begin
                if ($urandom_range(0, 9) == 0)
                    run_len = $urandom_range(1, cap);
                else
                    run_len = $urandom_range(1, (cap < 6) ? cap : 6);
                case ($urandom_range(0, 9))
                    0: extra = 1;
                    1: extra = (run_len > 1) ? -1 : 0;
                    default: extra = 0;
                endcase
                it.opcode     = mbrq_pkg::OP_PUSH;
                it.run_length = mbrq_pkg::LEN_W'(run_len);
                for (k = 0; k < run_len + extra; k++) begin
                    it.data_in   = mbrq_pkg::DATA_W'($urandom_range(0, 255));
                    it.run_first = (k == 0);
                    send_cmd(it, 1'b0, '0);
                    sent++;
                end
            end
            else if (pick < 80) begin
                it.opcode = mbrq_pkg::OP_POP;
                case ($urandom_range(0, 3))
                    0: it.run_length = '0;
                    1: it.run_length = mbrq_pkg::LEN_W'($urandom_range(1, f + 1));
                    2: it.run_length = mbrq_pkg::LEN_W'(f + $urandom_range(1, 3));
                    default: it.run_length = mbrq_pkg::LEN_W'($urandom_range(1,
                                                                 (f > 1) ? f : 1));
                endcase
                send_cmd(it, 1'b0, '0);
                sent++;
            end
            else begin
                it.opcode = (pick < 92) ? mbrq_pkg::OP_QUERY : mbrq_pkg::OP_CLEAR;
                send_cmd(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none when quiet
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        mbrq_pkg::out_item_t got;
        mbrq_pkg::out_item_t want;
        if (rst_n && result_if.valid && result_if.ready) begin
            got = result_if.payload;
            if (pending_results.size() == 0)
                report_mismatch({"result with nothing expected: ", show_result(got)});
            else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.data_out !== want.data_out ||
                    got.last !== want.last || got.popped_count !== want.popped_count ||
                    got.fill_count !== want.fill_count || got.is_empty !== want.is_empty ||
                    got.is_full !== want.is_full)
                    report_mismatch({"expected ", show_result(want),
                                     " got ", show_result(got)});
            end
        end
    end

    // Watchdog on cycles with no handshake and no register write
    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (result_if.valid && result_if.ready) || cfg_wr_en)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("multi_channel_byte_ring_queue_test: done, errors");
            $finish;
        end
    end

    initial begin
        int c, p;
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        for (c = 0; c < NCFG; c++)
            cap_reg[c] = '0;
        for (c = 0; c < NCH; c++)
            clear_channel(c);
        for (c = 0; c < NCH*RING_DEPTH; c++)
            ring_mem[c] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Nothing set up after reset
        plan_item(mbrq_pkg::OP_QUERY, 0, 8'h00, 0, 1'b0, 1'b1, mbrq_pkg::ST_NOT_SETUP, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH,  1, 8'hFF, 1, 1'b1, 1'b1, mbrq_pkg::ST_NOT_SETUP, 0, 1'b0);
        plan_item(mbrq_pkg::OP_POP,   2, 8'h00, 0, 1'b0, 1'b1, mbrq_pkg::ST_NOT_SETUP, 0, 1'b0);
        plan_item(mbrq_pkg::OP_CLEAR, 3, 8'h00, 0, 1'b0, 1'b1, mbrq_pkg::ST_OK,        0, 1'b0);
        plan_cfg(0, 4);
        plan_cfg(1, RING_DEPTH);
        plan_cfg(2, 127);
        plan_cfg(3, 1);
        // Empty pops, bad run starts, then a run that fills channel 0 and overflows
        plan_item(mbrq_pkg::OP_POP,  0, 8'h00, 0, 1'b0, 1'b1, mbrq_pkg::ST_OK,      0, 1'b0);
        plan_item(mbrq_pkg::OP_POP,  0, 8'h00, 1, 1'b0, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h12, 0, 1'b1, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h33, 2, 1'b0, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h44, 5, 1'b1, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h00, 2, 1'b1, 1'b1, mbrq_pkg::ST_OK,      1, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'hFF, 2, 1'b0, 1'b1, mbrq_pkg::ST_OK,      2, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'hA5, 2, 1'b0, 1'b1, mbrq_pkg::ST_OK,      3, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h5A, 2, 1'b0, 1'b1, mbrq_pkg::ST_OK,      4, 1'b1);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h11, 2, 1'b0, 1'b1, mbrq_pkg::ST_REFUSED, 4, 1'b1);
        plan_item(mbrq_pkg::OP_POP,  0, 8'h00, 5, 1'b0, 1'b1, mbrq_pkg::ST_REFUSED, 4, 1'b1);
        plan_item(mbrq_pkg::OP_POP,  0, 8'h00, 3, 1'b0, 1'b0, mbrq_pkg::ST_OK,      0, 1'b0);
        // Wrap the channel 0 indices and drain it all
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h7F, 3, 1'b1, 1'b0, mbrq_pkg::ST_OK, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'h80, 3, 1'b0, 1'b0, mbrq_pkg::ST_OK, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH, 0, 8'hC3, 3, 1'b0, 1'b0, mbrq_pkg::ST_OK, 0, 1'b0);
        plan_item(mbrq_pkg::OP_POP,  0, 8'h00, 0, 1'b0, 1'b0, mbrq_pkg::ST_OK, 0, 1'b0);
        // One-byte channel, and the saturated 64-byte capacity
        plan_item(mbrq_pkg::OP_PUSH,  3, 8'h80,   1, 1'b1, 1'b1, mbrq_pkg::ST_OK,      1, 1'b1);
        plan_item(mbrq_pkg::OP_QUERY, 3, 8'h00,   0, 1'b0, 1'b1, mbrq_pkg::ST_OK,      1, 1'b1);
        plan_item(mbrq_pkg::OP_CLEAR, 3, 8'h00,   0, 1'b0, 1'b1, mbrq_pkg::ST_OK,      0, 1'b0);
        plan_item(mbrq_pkg::OP_POP,   1, 8'h00, 127, 1'b0, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH,  2, 8'hFF, 127, 1'b1, 1'b1, mbrq_pkg::ST_REFUSED, 0, 1'b0);
        plan_item(mbrq_pkg::OP_PUSH,  2, 8'hFF,  64, 1'b1, 1'b1, mbrq_pkg::ST_OK,      1, 1'b0);

        foreach (dir_plan[i]) begin
            if (dir_plan[i].is_cfg)
                write_capacity(dir_plan[i].reg_idx, dir_plan[i].reg_val);
            else
                send_cmd(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].res);
        end

        for (p = 0; p < 5; p++) begin
            for (c = 0; c < NCFG; c++)
                write_capacity(c, (p == 4 && c < 2) ? RING_DEPTH : pick_capacity());
            if (p == 1)
                hold_req = 1'b1;
            if (p == 4)
                quiet = 1'b1;
            run_random(25, (p == 2) ? 12 : -1);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("multi_channel_byte_ring_queue_test: done, clean");
        else
            $display("multi_channel_byte_ring_queue_test: done, errors");
        $finish;
    end

endmodule
